[rtl/core/tmcw_pkg.sv]
// Shared types, constants and helpers for the text-mode console writer.
// No dependencies; every other file in rtl/core uses this package.
package tmcw_pkg;

  localparam int COLS       = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = COLS * ROWS;
  localparam int COPY_CELLS = COLS * (ROWS - 1);
  localparam int ADDR_W     = $clog2(CELLS);

  localparam int CMD_W  = 3;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;
  localparam int CLR_W  = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

  localparam logic [CLR_W-1:0] BG_RESET = 4'h0;
  localparam logic [CLR_W-1:0] FG_RESET = 4'hF;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 3'd0,
    CMD_CLEAR   = 3'd1,
    CMD_SET_COL = 3'd2,
    CMD_SET_ROW = 3'd3,
    CMD_READ    = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BACKGROUND = 1'b0,
    CFG_FOREGROUND = 1'b1
  } cfg_idx_t;

  // one request to the screen store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(COLS) + ADDR_W'(col);
  endfunction

  function automatic logic [COL_W-1:0] clamp_col(input logic [COL_W-1:0] col);
    return ({1'b0, col} >= (COL_W+1)'(COLS)) ? COL_W'(COLS - 1) : col;
  endfunction

  function automatic logic [ROW_W-1:0] clamp_row(input logic [ROW_W-1:0] row);
    return ({1'b0, row} >= (ROW_W+1)'(ROWS)) ? ROW_W'(ROWS - 1) : row;
  endfunction

endpackage

[rtl/core/tmcw_if.sv]
// Request and result channel interfaces for the console writer.
// Depends on tmcw_pkg for field widths.
interface tmcw_in_if;
  logic                         valid;
  logic                         ready;
  logic [tmcw_pkg::CMD_W-1:0]   command;
  logic [tmcw_pkg::CHAR_W-1:0]  char_code;
  logic [tmcw_pkg::COL_W-1:0]   col;
  logic [tmcw_pkg::ROW_W-1:0]   row;

  modport source (output valid, command, char_code, col, row, input ready);
  modport sink   (input valid, command, char_code, col, row, output ready);
endinterface

interface tmcw_out_if;
  logic                         valid;
  logic                         ready;
  logic [tmcw_pkg::COL_W-1:0]   cursor_col;
  logic [tmcw_pkg::ROW_W-1:0]   cursor_row;
  logic [tmcw_pkg::CELL_W-1:0]  read_cell;
  logic                         scrolled;

  modport source (output valid, cursor_col, cursor_row, read_cell, scrolled, input ready);
  modport sink   (input valid, cursor_col, cursor_row, read_cell, scrolled, output ready);
endinterface

[rtl/core/tmcw_screen_ram.sv]
// Screen cell store: one write port, one read port with registered data.
// Depends on tmcw_pkg.
module tmcw_screen_ram (
  input  logic                        clk,
  input  tmcw_pkg::mem_req_t          req,
  output logic [tmcw_pkg::CELL_W-1:0] rd_data
);
  import tmcw_pkg::*;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/text_mode_console_writer_top.sv]
// Text-mode console writer, 80x25 cells, top level. Uses tmcw_pkg, tmcw_if, tmcw_screen_ram.
// Set column/row and unused commands answer directly; a read waits for the registered store data;
// a character is one store write, a newline none and a tab four; a scroll and a clear each walk every cell.
// One request at a time: the sequencer, the store walk and result back-pressure set the rate.
// Reset is synchronous; afterwards a pass over every cell zeroes the store with in_ch.ready low.
module text_mode_console_writer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  tmcw_in_if.sink                        in_ch,
  tmcw_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [tmcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tmcw_pkg::CLR_W-1:0]     cfg_wdata
);
  import tmcw_pkg::*;

  typedef enum logic [6:0] {
    ST_FILL   = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_PUT    = 7'b0000100,
    ST_SCROLL = 7'b0001000,
    ST_DRAIN  = 7'b0010000,
    ST_READ   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]  wr_addr_r, wr_addr_nxt;
  logic               pend_r, pend_nxt;
  logic               pend_blank_r, pend_blank_nxt;
  logic               fill_zero_r, fill_zero_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   line_r, line_nxt;
  logic [CHAR_W-1:0]  ch_r, ch_nxt;
  logic [1:0]         rem_r, rem_nxt;
  logic               more_r, more_nxt;
  logic               scr_r, scr_nxt;
  logic [CELL_W-1:0]  cell_r, cell_nxt;
  logic [CLR_W-1:0]   bg_r, fg_r;

  logic               out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]   out_col_r, out_col_nxt;
  logic [ROW_W-1:0]   out_row_r, out_row_nxt;
  logic [CELL_W-1:0]  out_cell_r, out_cell_nxt;
  logic               out_scr_r, out_scr_nxt;

  mem_req_t           mem_req;
  logic [CELL_W-1:0]  mem_rd_data;
  logic [CELL_W-1:0]  blank;
  logic [COL_W:0]     col_inc;
  logic               wrap;
  logic               at_last_row;

  tmcw_screen_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  assign blank       = {bg_r, fg_r, CH_SPACE};
  assign col_inc     = {1'b0, col_r} + (COL_W+1)'(1);
  assign wrap        = (ch_r == CH_NEWLINE) || (col_inc >= (COL_W+1)'(COLS));
  assign at_last_row = (line_r == ROW_W'(ROWS - 1));

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.cursor_col = out_col_r;
  assign out_ch.cursor_row = out_row_r;
  assign out_ch.read_cell  = out_cell_r;
  assign out_ch.scrolled   = out_scr_r;

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    wr_addr_nxt    = wr_addr_r;
    pend_nxt       = pend_r;
    pend_blank_nxt = pend_blank_r;
    fill_zero_nxt  = fill_zero_r;
    col_nxt        = col_r;
    line_nxt       = line_r;
    ch_nxt         = ch_r;
    rem_nxt        = rem_r;
    more_nxt       = more_r;
    scr_nxt        = scr_r;
    cell_nxt       = cell_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    out_cell_nxt   = out_cell_r;
    out_scr_nxt    = out_scr_r;
    mem_req        = '0;

    case (state_r)
      ST_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_r;
        mem_req.wdata = fill_zero_r ? '0 : blank;
        ptr_nxt       = ptr_r + ADDR_W'(1);
        if (ptr_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = fill_zero_r ? ST_IDLE : ST_DONE;
        end
      end

      ST_IDLE: begin
        if (in_ch.valid) begin
          scr_nxt  = 1'b0;
          cell_nxt = '0;
          case (in_ch.command)
            CMD_WRITE: begin
              ch_nxt    = (in_ch.char_code == CH_TAB) ? CH_SPACE : in_ch.char_code;
              rem_nxt   = (in_ch.char_code == CH_TAB) ? 2'd3 : 2'd0;
              state_nxt = ST_PUT;
            end
            CMD_CLEAR: begin
              ptr_nxt       = '0;
              fill_zero_nxt = 1'b0;
              col_nxt       = '0;
              line_nxt      = '0;
              state_nxt     = ST_FILL;
            end
            CMD_SET_COL: begin
              col_nxt   = clamp_col(in_ch.col);
              state_nxt = ST_DONE;
            end
            CMD_SET_ROW: begin
              line_nxt  = clamp_row(in_ch.row);
              state_nxt = ST_DONE;
            end
            CMD_READ: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = cell_addr(clamp_row(in_ch.row), clamp_col(in_ch.col));
              state_nxt     = ST_READ;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_PUT: begin
        mem_req.we    = (ch_r != CH_NEWLINE);
        mem_req.waddr = cell_addr(line_r, col_r);
        mem_req.wdata = {bg_r, fg_r, ch_r};
        more_nxt      = (rem_r != 2'd0);
        if (rem_r != 2'd0) begin
          rem_nxt = rem_r - 2'd1;
        end
        if (wrap) begin
          col_nxt = '0;
          if (at_last_row) begin
            // past the bottom: shift everything up one row
            scr_nxt   = 1'b1;
            ptr_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = ST_SCROLL;
          end else begin
            line_nxt  = line_r + ROW_W'(1);
            state_nxt = (rem_r != 2'd0) ? ST_PUT : ST_DONE;
          end
        end else begin
          col_nxt   = col_inc[COL_W-1:0];
          state_nxt = (rem_r != 2'd0) ? ST_PUT : ST_DONE;
        end
      end

      ST_SCROLL: begin
        // read one row ahead, write back in the next cycle; last row gets blanks
        mem_req.we    = pend_r;
        mem_req.waddr = wr_addr_r;
        mem_req.wdata = pend_blank_r ? blank : mem_rd_data;
        pend_nxt      = 1'b1;
        wr_addr_nxt   = ptr_r;
        if (ptr_r < ADDR_W'(COPY_CELLS)) begin
          mem_req.re     = 1'b1;
          mem_req.raddr  = ptr_r + ADDR_W'(COLS);
          pend_blank_nxt = 1'b0;
        end else begin
          pend_blank_nxt = 1'b1;
        end
        ptr_nxt = ptr_r + ADDR_W'(1);
        if (ptr_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        mem_req.we    = pend_r;
        mem_req.waddr = wr_addr_r;
        mem_req.wdata = pend_blank_r ? blank : mem_rd_data;
        pend_nxt      = 1'b0;
        state_nxt     = more_r ? ST_PUT : ST_DONE;
      end

      ST_READ: begin
        cell_nxt  = mem_rd_data;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = col_r;
          out_row_nxt   = line_r;
          out_cell_nxt  = cell_r;
          out_scr_nxt   = scr_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      fill_zero_r <= 1'b1;
      col_r       <= '0;
      line_r      <= '0;
      rem_r       <= '0;
      more_r      <= 1'b0;
      out_valid_r <= 1'b0;
      bg_r        <= BG_RESET;
      fg_r        <= FG_RESET;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      fill_zero_r <= fill_zero_nxt;
      col_r       <= col_nxt;
      line_r      <= line_nxt;
      rem_r       <= rem_nxt;
      more_r      <= more_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BACKGROUND: bg_r <= cfg_wdata;
          CFG_FOREGROUND: fg_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r    <= wr_addr_nxt;
    pend_blank_r <= pend_blank_nxt;
    ch_r         <= ch_nxt;
    scr_r        <= scr_nxt;
    cell_r       <= cell_nxt;
    out_col_r    <= out_col_nxt;
    out_row_r    <= out_row_nxt;
    out_cell_r   <= out_cell_nxt;
    out_scr_r    <= out_scr_nxt;
  end

endmodule

[bench/tb_text_mode_console_writer_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for text_mode_console_writer_top: random and directed console requests,
// predicted against a shadow screen. Needs tmcw_pkg, tmcw_if and the RTL of the block.

typedef struct packed {
  logic [tmcw_pkg::COL_W-1:0]  cursor_col;
  logic [tmcw_pkg::ROW_W-1:0]  cursor_row;
  logic [tmcw_pkg::CELL_W-1:0] read_cell;
  logic                        scrolled;
} console_reply_t;

// Shadow copy of the screen and cursor; predicts one reply per accepted request.
class console_shadow;
  logic [tmcw_pkg::CELL_W-1:0] cells [tmcw_pkg::CELLS];
  int unsigned cur_col;
  int unsigned cur_row;
  logic [tmcw_pkg::CLR_W-1:0] bg_colour;
  logic [tmcw_pkg::CLR_W-1:0] fg_colour;
  console_reply_t expected_replies [$];
  int unsigned errors;
  int unsigned checked;
  int unsigned scrolls;
  int unsigned clears;
  int unsigned reads;

  function new();
    foreach (cells[i]) cells[i] = '0;
    cur_col   = 0;
    cur_row   = 0;
    bg_colour = tmcw_pkg::BG_RESET;
    fg_colour = tmcw_pkg::FG_RESET;
    errors    = 0;
    checked   = 0;
    scrolls   = 0;
    clears    = 0;
    reads     = 0;
  endfunction

  function void set_colour(tmcw_pkg::cfg_idx_t idx, logic [tmcw_pkg::CLR_W-1:0] value);
    if (idx == tmcw_pkg::CFG_BACKGROUND) bg_colour = value;
    else fg_colour = value;
  endfunction

  function int unsigned pending();
    return expected_replies.size();
  endfunction

  function logic [tmcw_pkg::CELL_W-1:0] coloured(logic [tmcw_pkg::CHAR_W-1:0] ch);
    return {bg_colour, fg_colour, ch};
  endfunction

  function void scroll_screen();
    for (int i = 0; i < tmcw_pkg::COPY_CELLS; i++) cells[i] = cells[i + tmcw_pkg::COLS];
    for (int x = 0; x < tmcw_pkg::COLS; x++)
      cells[tmcw_pkg::COPY_CELLS + x] = coloured(tmcw_pkg::CH_SPACE);
  endfunction

  // one byte at the cursor; returns 1 when the screen had to scroll
  function bit put_byte(logic [tmcw_pkg::CHAR_W-1:0] ch);
    if (ch == tmcw_pkg::CH_NEWLINE) begin
      cur_col = 0;
      cur_row++;
    end else begin
      cells[cur_row * tmcw_pkg::COLS + cur_col] = coloured(ch);
      cur_col++;
    end
    if (cur_col >= tmcw_pkg::COLS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= tmcw_pkg::ROWS) begin
      scroll_screen();
      cur_col = 0;
      cur_row = tmcw_pkg::ROWS - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void note_request(logic [tmcw_pkg::CMD_W-1:0] cmd, logic [tmcw_pkg::CHAR_W-1:0] ch,
                             logic [tmcw_pkg::COL_W-1:0] col, logic [tmcw_pkg::ROW_W-1:0] row);
    console_reply_t exp;
    int unsigned c;
    int unsigned r;
    exp = '0;
    c = (col >= tmcw_pkg::COLS) ? tmcw_pkg::COLS - 1 : col;
    r = (row >= tmcw_pkg::ROWS) ? tmcw_pkg::ROWS - 1 : row;
    case (cmd)
      tmcw_pkg::CMD_WRITE: begin
        if (ch == tmcw_pkg::CH_TAB) begin
          // each space may wrap and scroll on its own
          repeat (4) if (put_byte(tmcw_pkg::CH_SPACE)) exp.scrolled = 1'b1;
        end else begin
          exp.scrolled = put_byte(ch);
        end
      end
      tmcw_pkg::CMD_CLEAR: begin
        foreach (cells[i]) cells[i] = coloured(tmcw_pkg::CH_SPACE);
        cur_col = 0;
        cur_row = 0;
        clears++;
      end
      tmcw_pkg::CMD_SET_COL: cur_col = c;
      tmcw_pkg::CMD_SET_ROW: cur_row = r;
      tmcw_pkg::CMD_READ: begin
        exp.read_cell = cells[r * tmcw_pkg::COLS + c];
        reads++;
      end
      default: ;
    endcase
    if (exp.scrolled) scrolls++;
    exp.cursor_col = tmcw_pkg::COL_W'(cur_col);
    exp.cursor_row = tmcw_pkg::ROW_W'(cur_row);
    expected_replies.push_back(exp);
  endfunction

  function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_val, act_val);
    end
  endfunction

  function void check_result(console_reply_t got);
    console_reply_t exp;
    if (expected_replies.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual col %0d row %0d cell 0x%h scr %b",
               $time, got.cursor_col, got.cursor_row, got.read_cell, got.scrolled);
      return;
    end
    exp = expected_replies.pop_front();
    checked++;
    compare_field("cursor_col", exp.cursor_col, got.cursor_col);
    compare_field("cursor_row", exp.cursor_row, got.cursor_row);
    compare_field("read_cell", exp.read_cell, got.read_cell);
    compare_field("scrolled", exp.scrolled, got.scrolled);
  endfunction
endclass

module tb_text_mode_console_writer_top;
  import tmcw_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 40000;   // a tab with a scroll plus a hold-off fits easily
  localparam int RUN_LIMIT   = 3000000;
  localparam int PHASE_ITEMS = 226;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CLR_W-1:0] cfg_wdata;

  tmcw_in_if  req_if ();
  tmcw_out_if res_if ();

  text_mode_console_writer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_if),
    .out_ch    (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  console_shadow shadow;
  bit idling = 1'b1;
  bit hold_off_pending = 1'b0;
  int unsigned settings_used = 0;
  int unsigned stall_cycles = 0;
  int unsigned cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // request and result monitors, plus the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (res_if.valid && res_if.ready)
        shadow.check_result('{res_if.cursor_col, res_if.cursor_row, res_if.read_cell,
                              res_if.scrolled});
      if (req_if.valid && req_if.ready)
        shadow.note_request(req_if.command, req_if.char_code, req_if.col, req_if.row);
    end
    cycle_count <= cycle_count + 1;
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT || cycle_count > RUN_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result receiver: random back-pressure and one long hold-off on request
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_pending = 1'b0;
      end else if (idling && $urandom_range(99) < 23) begin
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                              input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
    if (idling && $urandom_range(99) < 23) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.command   <= cmd;
    req_if.char_code <= ch;
    req_if.col       <= col;
    req_if.row       <= row;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // stop offering and wait until every outstanding request has its result;
  // first wait on the clock so the monitor has noted the last accepted request
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  task automatic write_colours(input logic [CLR_W-1:0] bg, input logic [CLR_W-1:0] fg);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BACKGROUND;
    cfg_wdata <= bg;
    @(posedge clk);
    shadow.set_colour(CFG_BACKGROUND, bg);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FOREGROUND;
    cfg_wdata <= fg;
    @(posedge clk);
    shadow.set_colour(CFG_FOREGROUND, fg);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic random_request();
    int unsigned pick;
    int unsigned sub;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    pick = $urandom_range(99);
    sub  = $urandom_range(99);
    ch   = CHAR_W'($urandom);
    col  = COL_W'($urandom);
    row  = ROW_W'($urandom);
    if (pick < 58) begin
      if (sub < 8) ch = CH_NEWLINE;
      else if (sub < 13) ch = CH_TAB;
      send_request(CMD_WRITE, ch, col, row);
    end else if (pick < 70) begin
      if (sub >= 10) col = COL_W'($urandom_range(COLS - 1));
      send_request(CMD_SET_COL, ch, col, row);
    end else if (pick < 80) begin
      // lean on the bottom row so that scrolling gets exercised
      if (sub < 25) row = ROW_W'(ROWS - 1);
      else if (sub >= 35) row = ROW_W'($urandom_range(ROWS - 1));
      send_request(CMD_SET_ROW, ch, col, row);
    end else if (pick < 94) begin
      if (sub >= 10) begin
        col = COL_W'($urandom_range(COLS - 1));
        row = ROW_W'($urandom_range(ROWS - 1));
      end
      send_request(CMD_READ, ch, col, row);
    end else if (pick < 95) begin
      send_request(CMD_CLEAR, ch, col, row);
    end else begin
      send_request(CMD_W'(CMD_READ) + CMD_W'($urandom_range(1, 3)), ch, col, row);
    end
  endtask

  task automatic random_phase(input logic [CLR_W-1:0] bg, input logic [CLR_W-1:0] fg,
                              input bit with_hold_off, input bit with_pause);
    write_colours(bg, fg);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (with_hold_off && n == PHASE_ITEMS / 3) hold_off_pending = 1'b1;
      if (with_pause && n == PHASE_ITEMS / 2) drain();
      random_request();
    end
    drain();
    repeat (4) @(posedge clk);
  endtask

  initial begin
    shadow = new();
    rst_n            <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.command   <= CMD_WRITE;
    req_if.char_code <= '0;
    req_if.col       <= '0;
    req_if.row       <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_BACKGROUND;
    cfg_wdata        <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: edges of every field and each corner of the cursor logic
    write_colours(BG_RESET, FG_RESET);
    send_request(CMD_READ, 8'h00, 7'd0, 5'd0);
    send_request(CMD_WRITE, 8'h41, 7'd0, 5'd0);
    send_request(CMD_WRITE, 8'h00, 7'd0, 5'd0);
    send_request(CMD_WRITE, 8'hFF, 7'd0, 5'd0);
    send_request(CMD_WRITE, CH_NEWLINE, 7'd0, 5'd0);
    send_request(CMD_WRITE, CH_TAB, 7'd0, 5'd0);
    send_request(CMD_READ, 8'h00, 7'd0, 5'd0);
    send_request(CMD_READ, 8'h00, 7'd2, 5'd0);
    send_request(CMD_SET_COL, 8'h00, 7'h7F, 5'd0);
    send_request(CMD_SET_ROW, 8'h00, 7'd0, 5'h1F);
    send_request(CMD_WRITE, 8'h7E, 7'd0, 5'd0);          // bottom-right corner: wrap and scroll
    send_request(CMD_READ, 8'h00, 7'h7F, 5'h1F);
    send_request(CMD_SET_COL, 8'h00, 7'd78, 5'd0);
    send_request(CMD_WRITE, CH_TAB, 7'd0, 5'd0);         // tab straddling the last row
    send_request(CMD_WRITE, CH_NEWLINE, 7'd0, 5'd0);     // newline on the last row
    send_request(CMD_READ, 8'h00, 7'd1, 5'd23);
    for (int k = 1; k <= 3; k++)
      send_request(CMD_W'(CMD_READ) + CMD_W'(k), 8'hFF, 7'h7F, 5'h1F);
    send_request(CMD_SET_COL, 8'h00, 7'(COLS), 5'd0);
    send_request(CMD_SET_ROW, 8'h00, 7'd0, 5'(ROWS));
    send_request(CMD_CLEAR, 8'h00, 7'd0, 5'd0);
    send_request(CMD_READ, 8'h00, 7'd40, 5'd12);
    drain();
    repeat (4) @(posedge clk);

    random_phase(4'hF, 4'h0, 1'b0, 1'b0);
    idling = 1'b0;
    random_phase(4'h0, 4'h0, 1'b0, 1'b0);
    idling = 1'b1;
    random_phase(4'hF, 4'hF, 1'b1, 1'b0);
    random_phase(CLR_W'($urandom), CLR_W'($urandom), 1'b0, 1'b1);
    random_phase(CLR_W'($urandom), CLR_W'($urandom), 1'b0, 1'b0);

    repeat (20) @(posedge clk);
    if (shadow.pending() != 0) begin
      shadow.errors++;
      $display("%0t: %0d results never arrived", $time, shadow.pending());
    end
    $display("Checked %0d results over %0d colour settings: %0d reads, %0d scrolling requests,",
             shadow.checked, settings_used, shadow.reads, shadow.scrolls);
    $display("%0d clears, with back-pressure, a long result hold-off and a drained pause.",
             shadow.clears);
    if (shadow.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/tmcw_pkg.sv
rtl/core/tmcw_if.sv
rtl/core/tmcw_screen_ram.sv
rtl/core/text_mode_console_writer_top.sv
bench/tb_text_mode_console_writer_top.sv
